// File: sv/sspq_pkg.sv
// Shared types, sizes and codes of the stable sorted priority queue.
package sspq_pkg;

    localparam int DEPTH          = 16;
    localparam int PAYLOAD_WIDTH  = 32;
    localparam int PRIORITY_WIDTH = 16;
    localparam int COUNT_W        = $clog2(DEPTH + 1);

    // Operation codes carried in the func field.
    typedef enum logic {
        FUNC_ENQ = 1'b0,
        FUNC_DEQ = 1'b1
    } t_func;

    // Status codes of a result item.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // One stored entry.
    typedef struct packed {
        logic signed [PRIORITY_WIDTH-1:0] prio;
        logic [PAYLOAD_WIDTH-1:0]         data;
    } t_entry;

    // Command broadcast from the top level to every cell.
    typedef struct packed {
        logic   enq;
        logic   deq;
        t_entry entry;
    } t_cmd;

    // Request item.
    typedef struct packed {
        logic                             func;
        logic signed [PRIORITY_WIDTH-1:0] priority_req;
        logic [PAYLOAD_WIDTH-1:0]         payload;
    } t_in_item;

    // Result item.
    typedef struct packed {
        logic                             out_valid;
        logic [PAYLOAD_WIDTH-1:0]         out_payload;
        logic signed [PRIORITY_WIDTH-1:0] out_priority;
        logic [1:0]                       status;
        logic                             is_empty;
        logic [COUNT_W-1:0]               entry_count;
        logic signed [PRIORITY_WIDTH-1:0] head_priority;
        logic [PAYLOAD_WIDTH-1:0]         head_payload;
    } t_out_item;

endpackage

// File: sv/sspq_in_if.sv
// Request channel of the priority queue: valid, ready and one request item.
interface sspq_in_if;
    logic              valid;
    logic              ready;
    sspq_pkg::t_in_item item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

// File: sv/sspq_out_if.sv
// Result channel of the priority queue: valid, ready and one result item.
interface sspq_out_if;
    logic               valid;
    logic               ready;
    sspq_pkg::t_out_item item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

// File: sv/sspq_cell.sv
// One slot of the sorted chain: holds an entry and moves it left or right.
module sspq_cell (
    input  logic             i_clk,
    input  sspq_pkg::t_cmd   i_cmd,
    input  logic             i_occ,
    input  logic             i_prev_le,
    input  sspq_pkg::t_entry i_left,
    input  sspq_pkg::t_entry i_right,
    output sspq_pkg::t_entry o_entry,
    output logic             o_le
);

    sspq_pkg::t_entry r_entry;
    sspq_pkg::t_entry n_entry;

    // The entry here stays ahead of a new one when it is stored and not larger.
    assign o_le    = i_occ && (r_entry.prio <= i_cmd.entry.prio);
    assign o_entry = r_entry;

    // Enqueue: keep, take the new entry, or take the left neighbor's entry.
    // Dequeue: take the right neighbor's entry.
    always_comb begin
        n_entry = r_entry;
        if (i_cmd.enq) begin
            if (!o_le) begin
                n_entry = i_prev_le ? i_cmd.entry : i_left;
            end
        end else if (i_cmd.deq) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

// File: sv/stable_sorted_priority_queue.sv
// Top level of the stable sorted priority queue built from a chain of cells.
//
//  Port    | Dir | Moves                              | Accepted when
//  i_req   | in  | func, priority_req, payload        | valid && ready
//  o_rsp   | out | status, dequeued entry, head, count | valid && ready
//
// Every accepted request gives one result item in the next cycle, and a new
// request can be accepted in every cycle. The path per cycle is one priority
// compare in each cell and a four-way select of its entry.
// Reset clears the entry count and the result valid flag; stored entries are
// not cleared, since only the first count of them are ever read.
// Requests stall only while a result waits in the output register and the
// result side does not take it.
module stable_sorted_priority_queue (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sspq_in_if.sink    i_req,
    sspq_out_if.source o_rsp
);

    localparam int D = sspq_pkg::DEPTH;
    localparam int CW = sspq_pkg::COUNT_W;

    logic [CW-1:0]       r_count;
    logic [CW-1:0]       n_count;
    logic                r_rsp_valid;
    sspq_pkg::t_out_item r_rsp;
    sspq_pkg::t_out_item n_rsp;

    sspq_pkg::t_cmd      w_cmd;
    sspq_pkg::t_entry    w_entry [D];
    logic                w_le    [D];
    logic                w_accept;
    logic                w_full;
    logic                w_empty;
    logic                w_is_deq;
    sspq_pkg::t_entry    w_head;
    logic                w_sorted;

    assign i_req.ready = !r_rsp_valid || o_rsp.ready;
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_full      = (r_count == CW'(D));
    assign w_empty     = (r_count == '0);
    assign w_is_deq    = (i_req.item.func == sspq_pkg::FUNC_DEQ);

    // Command seen by every cell.
    always_comb begin
        w_cmd.enq        = w_accept && !w_is_deq && !w_full;
        w_cmd.deq        = w_accept && w_is_deq && !w_empty;
        w_cmd.entry.prio = i_req.item.priority_req;
        w_cmd.entry.data = i_req.item.payload;
    end

    // Chain of cells; each sees its neighbors and whether it holds an entry.
    for (genvar g = 0; g < D; g++) begin : g_cell
        sspq_cell u_cell (
            .i_clk     (i_clk),
            .i_cmd     (w_cmd),
            .i_occ     (r_count > CW'(g)),
            .i_prev_le ((g == 0) ? 1'b1 : w_le[(g == 0) ? 0 : g - 1]),
            .i_left    ((g == 0) ? w_cmd.entry : w_entry[(g == 0) ? 0 : g - 1]),
            .i_right   ((g == D - 1) ? w_entry[g] : w_entry[(g == D - 1) ? g : g + 1]),
            .o_entry   (w_entry[g]),
            .o_le      (w_le[g])
        );
    end

    // Entry count after the operation.
    always_comb begin
        n_count = r_count;
        if (w_cmd.enq) begin
            n_count = r_count + CW'(1);
        end else if (w_cmd.deq) begin
            n_count = r_count - CW'(1);
        end
    end

    // Head entry after the operation, taken from where cell zero will load it.
    always_comb begin
        w_head = w_entry[0];
        if (w_cmd.deq) begin
            w_head = w_entry[1];
        end else if (w_cmd.enq && !w_le[0]) begin
            w_head = w_cmd.entry;
        end
    end

    // Result item.
    always_comb begin
        n_rsp              = '0;
        n_rsp.status       = sspq_pkg::ST_OK;
        if (w_is_deq) begin
            if (w_empty) begin
                n_rsp.status = sspq_pkg::ST_EMPTY;
            end else begin
                n_rsp.out_valid    = 1'b1;
                n_rsp.out_payload  = w_entry[0].data;
                n_rsp.out_priority = w_entry[0].prio;
            end
        end else if (w_full) begin
            n_rsp.status = sspq_pkg::ST_FULL;
        end
        n_rsp.is_empty    = (n_count == '0);
        n_rsp.entry_count = n_count;
        if (n_count != '0) begin
            n_rsp.head_priority = w_head.prio;
            n_rsp.head_payload  = w_head.data;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_rsp_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp.valid = r_rsp_valid;
    assign o_rsp.item  = r_rsp;

    // Stored entries are in nondecreasing priority order.
    always_comb begin
        w_sorted = 1'b1;
        for (int k = 1; k < D; k++) begin
            if ((r_count > CW'(k)) && (w_entry[k].prio < w_entry[k-1].prio)) begin
                w_sorted = 1'b0;
            end
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(D))
        else $error("entry count above depth");

    a_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sorted)
        else $error("stored entries out of order");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.enq |=> (r_count == $past(r_count) + CW'(1)))
        else $error("enqueue did not add one entry");

    a_deq_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.deq |=> (r_rsp.out_valid && r_rsp.status == sspq_pkg::ST_OK))
        else $error("dequeue result not flagged valid");

endmodule
